// ===== rtl/aqp_pkg.sv =====
// Package for the audio sample quantize and pack block.
// Holds the fixed-point constants, format codes and the word passed
// between the quantizer and the byte serializer. Depends on nothing.
`timescale 1ns / 1ps

package aqp_pkg;

  // Binary point of the incoming fixed-point sample (unity = 2^FRAC_BITS).
  localparam int FRAC_BITS = 24;
  localparam int SAMPLE_W  = 32;
  localparam int CNT_W     = 32;
  localparam int SUM_W     = SAMPLE_W + 2;

  // Saturation limit (all but the 32-bit format) and rounding constant for the 8- and 16-bit formats.
  localparam int SAT_LIM   = (1 << FRAC_BITS) - 1;
  localparam int RND_CONST = 1 << (FRAC_BITS - 16);

  // Right shift that brings the clamped value to each output depth.
  localparam int SHIFT_8   = FRAC_BITS - 8 + 1;
  localparam int SHIFT_16  = FRAC_BITS - 16 + 1;
  localparam int SHIFT_24  = FRAC_BITS - 24 + 1;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef enum logic [1:0] {
    FMT_8  = 2'd0,
    FMT_16 = 2'd1,
    FMT_24 = 2'd2,
    FMT_32 = 2'd3
  } fmt_e;

  // Configuration register indexes.
  localparam logic [7:0] CFG_IDX_FORMAT = 8'd0;
  localparam logic [7:0] CFG_IDX_STEREO = 8'd1;

  // One quantized sample on its way to the serializer.
  typedef struct packed {
    logic             load;       // word is handed over this cycle
    logic [31:0]      pcm_word;   // PCM value, low bytes meaningful
    logic [1:0]       top_idx;    // index of the most significant byte
    logic             clipped;
    logic [CNT_W-1:0] clip_total;
    logic [CNT_W-1:0] peak_clip;
    logic [CNT_W-1:0] frames_done;
  } quant_word_t;

endpackage

// ===== rtl/audio_sample_quantize_pack_top.sv =====
// Top level of the audio sample quantize and pack block: configuration
// registers plus the quantizer and serializer. Depends on aqp_pkg,
// aqp_quant and aqp_serial.
//
// Usage: each word on the in_ channel is one signed fixed-point sample
// (unity = 2^24). It is rounded (8- and 16-bit formats), saturated to
// +/-(2^24 - 1) (all but the 32-bit format), shifted down to the chosen
// depth and sent as 1 to 4 bytes, most significant first, on the out_
// channel; out_tlast marks the final byte of a sample. Every byte also
// carries the clip flag, the clip count, the peak clipped magnitude and
// the frame count as they stand after that sample.
// The cfg_ channel writes sample_format (index 0) and stereo_mode
// (index 1); unknown indexes are ignored. It is always ready; the user must
// write it only while the block is idle, as the block does not enforce this.
// A sample word is held in the input register and then loaded into the
// serializer, which presents its first byte; a busy serializer holds it in
// the input register. The byte-wide result channel sets the pace: a sample
// is 1, 2, 3 or 4 bytes for the 8-, 16-, 24- and 32-bit formats, and the next
// sample is quantized while the last byte of the previous one is sent.
// Reset (rst_n low, synchronous) empties both stages, clears all
// counters and the channel phase and sets the format to 16 bit, mono.
// When the receiver stalls, the current byte holds and the input register
// fills; in_tready then drops until the serializer can take the next word.
`timescale 1ns / 1ps

module audio_sample_quantize_pack_top (
  input  logic         clk,
  input  logic         rst_n,
  // Input sample words.
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [31:0]  in_tdata,   // [31:0] sample_value (signed)
  // Output byte words.
  output logic         out_tvalid,
  input  logic         out_tready,
  // [7:0] out_byte, [8] sample_clipped, [40:9] clip_total,
  // [72:41] peak_clip, [104:73] frames_done, [111:105] zero
  output logic [111:0] out_tdata,
  output logic         out_tlast,  // last_byte
  // Configuration writes.
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [7:0]   cfg_index,
  input  logic [7:0]   cfg_data
);
  import aqp_pkg::*;

  fmt_e        fmt_r;
  logic        stereo_r;
  logic        ser_ready;
  quant_word_t qword;

  // Configuration is a plain register write; it never stalls.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r    <= FMT_16;
      stereo_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_IDX_FORMAT) begin
        fmt_r <= fmt_e'(cfg_data[1:0]);
      end else if (cfg_index == CFG_IDX_STEREO) begin
        stereo_r <= cfg_data[0];
      end
    end
  end

  aqp_quant u_quant (
    .clk       (clk),
    .rst_n     (rst_n),
    .fmt       (fmt_r),
    .stereo    (stereo_r),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .ser_ready (ser_ready),
    .qword     (qword)
  );

  aqp_serial u_serial (
    .clk        (clk),
    .rst_n      (rst_n),
    .qword      (qword),
    .ser_ready  (ser_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== rtl/aqp_quant.sv =====
// Quantizer stage: input register, rounding, saturation, shift and the
// clip and frame statistics. Depends on aqp_pkg.
`timescale 1ns / 1ps

module aqp_quant (
  input  logic                 clk,
  input  logic                 rst_n,
  input  aqp_pkg::fmt_e        fmt,
  input  logic                 stereo,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [31:0]          in_tdata,
  input  logic                 ser_ready,
  output aqp_pkg::quant_word_t qword
);
  import aqp_pkg::*;

  logic                  s1_valid_r;
  logic [SAMPLE_W-1:0]   s1_sample_r;
  logic [CNT_W-1:0]      clip_cnt_r, clip_cnt_nxt;
  logic [CNT_W-1:0]      peak_r, peak_nxt;
  logic [CNT_W-1:0]      frame_cnt_r, frame_cnt_nxt;
  logic                  phase_r, phase_nxt;
  logic                  take;

  logic signed [SUM_W-1:0] lim_s, sum, sat;
  logic [SUM_W-1:0]        mag;
  logic                    over_hi, over_lo, clipped;
  logic [31:0]             pcm_word;
  logic [1:0]              top_idx;

  assign take      = s1_valid_r && ser_ready;
  assign in_tready = !s1_valid_r || ser_ready;

  always_comb begin
    lim_s   = SUM_W'(SAT_LIM);
    sum     = SUM_W'($signed(s1_sample_r));
    if (fmt == FMT_8 || fmt == FMT_16) begin
      sum = sum + SUM_W'(RND_CONST);
    end
    over_hi = sum > lim_s;
    over_lo = sum < -lim_s;
    mag     = over_hi ? sum : -sum;
    if (over_hi) begin
      sat = lim_s;
    end else if (over_lo) begin
      sat = -lim_s;
    end else begin
      sat = sum;
    end
    clipped = (fmt != FMT_32) && (over_hi || over_lo);

    case (fmt)
      FMT_8: begin
        pcm_word = 32'(sat >>> SHIFT_8);
        top_idx  = 2'd0;
      end
      FMT_16: begin
        pcm_word = 32'(sat >>> SHIFT_16);
        top_idx  = 2'd1;
      end
      FMT_24: begin
        pcm_word = 32'(sat >>> SHIFT_24);
        top_idx  = 2'd2;
      end
      default: begin
        pcm_word = s1_sample_r;
        top_idx  = 2'd3;
      end
    endcase

    clip_cnt_nxt = clip_cnt_r;
    peak_nxt     = peak_r;
    if (clipped) begin
      if (clip_cnt_r != CNT_MAX) begin
        clip_cnt_nxt = clip_cnt_r + 1'b1;
      end
      // The magnitude of a clipped value never exceeds 2^31 + 2^8 - 1.
      if (mag > SUM_W'(peak_r)) begin
        peak_nxt = mag[CNT_W-1:0];
      end
    end

    frame_cnt_nxt = frame_cnt_r;
    if (stereo) begin
      if (phase_r && frame_cnt_r != CNT_MAX) begin
        frame_cnt_nxt = frame_cnt_r + 1'b1;
      end
      phase_nxt = !phase_r;
    end else begin
      if (frame_cnt_r != CNT_MAX) begin
        frame_cnt_nxt = frame_cnt_r + 1'b1;
      end
      phase_nxt = 1'b0;
    end
  end

  always_comb begin
    qword.load        = take;
    qword.pcm_word    = pcm_word;
    qword.top_idx     = top_idx;
    qword.clipped     = clipped;
    qword.clip_total  = clip_cnt_nxt;
    qword.peak_clip   = peak_nxt;
    qword.frames_done = frame_cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      clip_cnt_r  <= '0;
      peak_r      <= '0;
      frame_cnt_r <= '0;
      phase_r     <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        s1_valid_r <= 1'b1;
      end else if (take) begin
        s1_valid_r <= 1'b0;
      end
      if (take) begin
        clip_cnt_r  <= clip_cnt_nxt;
        peak_r      <= peak_nxt;
        frame_cnt_r <= frame_cnt_nxt;
        phase_r     <= phase_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_sample_r <= in_tdata;
    end
  end

endmodule

// ===== rtl/aqp_serial.sv =====
// Byte serializer: holds one quantized word and emits its bytes most
// significant first on the result channel. Depends on aqp_pkg.
`timescale 1ns / 1ps

module aqp_serial (
  input  logic                 clk,
  input  logic                 rst_n,
  input  aqp_pkg::quant_word_t qword,
  output logic                 ser_ready,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [111:0]         out_tdata,
  output logic                 out_tlast
);
  import aqp_pkg::*;

  logic             valid_r;
  logic [1:0]       idx_r;
  logic [31:0]      word_r;
  logic             clipped_r;
  logic [CNT_W-1:0] clip_total_r, peak_r, frames_r;
  logic [7:0]       cur_byte;
  logic             last;

  assign last       = (idx_r == 2'd0);
  assign ser_ready  = !valid_r || (out_tready && last);
  assign cur_byte   = word_r[{idx_r, 3'b000} +: 8];
  assign out_tvalid = valid_r;
  assign out_tlast  = last;
  assign out_tdata  = {7'd0, frames_r, peak_r, clip_total_r, clipped_r, cur_byte};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 2'd0;
    end else begin
      if (qword.load) begin
        valid_r <= 1'b1;
        idx_r   <= qword.top_idx;
      end else if (valid_r && out_tready) begin
        if (last) begin
          valid_r <= 1'b0;
        end else begin
          idx_r <= idx_r - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (qword.load) begin
      word_r       <= qword.pcm_word;
      clipped_r    <= qword.clipped;
      clip_total_r <= qword.clip_total;
      peak_r       <= qword.peak_clip;
      frames_r     <= qword.frames_done;
    end
  end

endmodule
